FILE: design/fdsn_pkg.sv
`default_nettype none
package fdsn_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int FIELD_BITS = 40;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // register index, taken from paddr[2]
    localparam logic REG_FORMAT_MODE    = 1'b0;
    localparam logic REG_SEPARATOR_CODE = 1'b1;

    localparam logic [BYTE_BITS-1:0] SEPARATOR_RESET = 8'd36;
    localparam logic                 FORMAT_RESET    = 1'b1;

    localparam logic [BYTE_BITS-1:0] CH_MARKER  = 8'h3E;
    localparam logic [BYTE_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_BITS-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CH_CASE_BIT = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_A = 8'h61;
    localparam logic [BYTE_BITS-1:0] CH_C = 8'h63;
    localparam logic [BYTE_BITS-1:0] CH_G = 8'h67;
    localparam logic [BYTE_BITS-1:0] CH_T = 8'h74;
    localparam logic [BYTE_BITS-1:0] CH_U = 8'h75;

    localparam int NUM_BASES = 4;
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef enum logic [1:0] {
        PH_EXPECT = 2'd0,
        PH_HEADER = 2'd1,
        PH_SEQ    = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    typedef struct packed {
        logic                 format_mode;
        logic [BYTE_BITS-1:0] separator_code;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 end_of_file;
    } t_item;

endpackage
`default_nettype wire

FILE: design/fdsn_if.sv
`default_nettype none
interface fdsn_in_if import fdsn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_file;

    modport source (output valid, data_byte, end_of_file, input ready);
    modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface fdsn_out_if import fdsn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [BYTE_BITS-1:0]  symbol;
    logic                  is_summary;
    logic                  status;
    logic [FIELD_BITS-1:0] count_a;
    logic [FIELD_BITS-1:0] count_c;
    logic [FIELD_BITS-1:0] count_g;
    logic [FIELD_BITS-1:0] count_t;
    logic [FIELD_BITS-1:0] input_count;
    logic [FIELD_BITS-1:0] output_count;

    modport source (output valid, symbol, is_summary, status, count_a, count_c, count_g,
                    count_t, input_count, output_count, input ready);
    modport sink   (input valid, symbol, is_summary, status, count_a, count_c, count_g,
                    count_t, input_count, output_count, output ready);
endinterface
`default_nettype wire

FILE: design/fdsn_cfg.sv
`default_nettype none
module fdsn_cfg import fdsn_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    logic                 r_format_mode;
    logic [BYTE_BITS-1:0] r_separator_code;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode    <= FORMAT_RESET;
            r_separator_code <= SEPARATOR_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FORMAT_MODE:    r_format_mode    <= pwdata[0];
                REG_SEPARATOR_CODE: r_separator_code <= pwdata[BYTE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FORMAT_MODE:    prdata = APB_DATA_BITS'(r_format_mode);
            REG_SEPARATOR_CODE: prdata = APB_DATA_BITS'(r_separator_code);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.format_mode    = r_format_mode;
    assign o_cfg.separator_code = r_separator_code;

endmodule
`default_nettype wire

FILE: design/fdsn_in_stage.sv
`default_nettype none
module fdsn_in_stage import fdsn_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fdsn_in_if.sink   i_in,
    input  wire logic i_advance,
    output logic      o_valid,
    output t_item     o_item
);

    logic  r_valid;
    t_item r_item;
    logic  in_ready;

    // stage frees up whenever the core takes the held item
    assign in_ready   = !r_valid || i_advance;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.end_of_file <= i_in.end_of_file;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: design/fdsn_core.sv
`default_nettype none
module fdsn_core import fdsn_pkg::*; #(
    parameter int COUNT_BITS = 40
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_item  i_item,
    input  wire t_cfg   i_cfg,
    output logic        o_advance,
    fdsn_out_if.source  o_out
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    t_phase r_phase, n_phase;
    logic   r_run, n_run;
    logic   r_nonempty, n_nonempty;

    logic [COUNT_BITS-1:0] r_base [NUM_BASES];
    logic [COUNT_BITS-1:0] u_base [NUM_BASES];
    logic [COUNT_BITS-1:0] r_consumed, u_consumed;
    logic [COUNT_BITS-1:0] r_emitted, u_emitted;

    logic                 step;
    logic                 seq;
    logic                 emit;
    logic                 clear;
    logic                 summ;
    logic                 stat;
    logic [BYTE_BITS-1:0] sym;
    logic [BYTE_BITS-1:0] lc;
    logic                 is_base;
    logic [1:0]           base_idx;
    logic [NUM_BASES-1:0] inc_base;
    logic                 inc_cons;
    logic                 inc_emit;

    logic                  r_out_valid;
    logic [BYTE_BITS-1:0]  r_symbol;
    logic                  r_is_summary;
    logic                  r_status;
    logic [FIELD_BITS-1:0] r_cnt_out [NUM_BASES];
    logic [FIELD_BITS-1:0] r_input_count;
    logic [FIELD_BITS-1:0] r_output_count;

    assign o_advance = !r_out_valid || o_out.ready;
    assign step      = i_valid && o_advance;

    // fold upper case and classify
    always_comb begin
        if (i_item.data_byte >= CH_UPPER_A && i_item.data_byte <= CH_UPPER_Z) begin
            lc = i_item.data_byte | CH_CASE_BIT;
        end else begin
            lc = i_item.data_byte;
        end
        is_base  = 1'b1;
        base_idx = BASE_A;
        case (lc)
            CH_A:        base_idx = BASE_A;
            CH_C:        base_idx = BASE_C;
            CH_G:        base_idx = BASE_G;
            CH_T, CH_U:  base_idx = BASE_T;
            default:     is_base  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_EXPECT;
            r_run      <= 1'b0;
            r_nonempty <= 1'b0;
        end else if (clear) begin
            r_phase    <= PH_EXPECT;
            r_run      <= 1'b0;
            r_nonempty <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_run      <= n_run;
            r_nonempty <= n_nonempty;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_run      = r_run;
        n_nonempty = r_nonempty;
        inc_base   = '0;
        inc_cons   = 1'b0;
        inc_emit   = 1'b0;
        emit       = 1'b0;
        sym        = '0;
        summ       = 1'b0;
        stat       = 1'b0;
        clear      = 1'b0;
        seq        = 1'b0;
        if (step) begin
            if (i_item.end_of_file) begin
                emit  = 1'b1;
                summ  = 1'b1;
                stat  = (r_phase == PH_ERROR) ||
                        (i_cfg.format_mode && (r_phase == PH_EXPECT));
                clear = 1'b1;
            end else if (!i_cfg.format_mode) begin
                seq = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_EXPECT: begin
                        n_phase = (i_item.data_byte == CH_MARKER) ? PH_HEADER : PH_ERROR;
                    end
                    PH_HEADER: begin
                        if (i_item.data_byte == CH_NEWLINE) begin
                            n_phase    = PH_SEQ;
                            n_run      = 1'b0;
                            n_nonempty = 1'b0;
                        end
                    end
                    PH_SEQ: begin
                        if (i_item.data_byte == CH_MARKER) begin
                            // record closes; separator only after a non-empty one
                            n_phase    = PH_HEADER;
                            n_nonempty = 1'b0;
                            if (r_nonempty) begin
                                emit     = 1'b1;
                                inc_emit = 1'b1;
                                sym      = i_cfg.separator_code;
                            end
                        end else if (i_item.data_byte != CH_NEWLINE) begin
                            seq = 1'b1;
                        end
                    end
                    PH_ERROR: ;
                    default: ;
                endcase
            end
            if (seq) begin
                inc_cons   = 1'b1;
                n_nonempty = 1'b1;
                if (is_base) begin
                    n_run              = 1'b0;
                    inc_base[base_idx] = 1'b1;
                    inc_emit           = 1'b1;
                    emit               = 1'b1;
                    sym                = lc;
                end else if (!r_run) begin
                    // first byte of a non-base run
                    n_run    = 1'b1;
                    inc_emit = 1'b1;
                    emit     = 1'b1;
                    sym      = i_cfg.separator_code;
                end
            end
        end
    end

    // saturating counter updates
    for (genvar k = 0; k < NUM_BASES; k++) begin : g_base
        assign u_base[k] = (inc_base[k] && (r_base[k] != CNT_MAX)) ?
                           r_base[k] + CNT_ONE : r_base[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || clear) begin
                r_base[k] <= '0;
            end else begin
                r_base[k] <= u_base[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (step && emit) begin
                r_cnt_out[k] <= FIELD_BITS'(u_base[k]);
            end
        end
    end

    assign u_consumed = (inc_cons && (r_consumed != CNT_MAX)) ?
                        r_consumed + CNT_ONE : r_consumed;
    assign u_emitted  = (inc_emit && (r_emitted != CNT_MAX)) ?
                        r_emitted + CNT_ONE : r_emitted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_consumed <= '0;
            r_emitted  <= '0;
        end else begin
            r_consumed <= u_consumed;
            r_emitted  <= u_emitted;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_symbol       <= sym;
            r_is_summary   <= summ;
            r_status       <= stat;
            r_input_count  <= FIELD_BITS'(u_consumed);
            r_output_count <= FIELD_BITS'(u_emitted);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.symbol       = r_symbol;
    assign o_out.is_summary   = r_is_summary;
    assign o_out.status       = r_status;
    assign o_out.count_a      = r_cnt_out[BASE_A];
    assign o_out.count_c      = r_cnt_out[BASE_C];
    assign o_out.count_g      = r_cnt_out[BASE_G];
    assign o_out.count_t      = r_cnt_out[BASE_T];
    assign o_out.input_count  = r_input_count;
    assign o_out.output_count = r_output_count;

endmodule
`default_nettype wire

FILE: design/fasta_dna_stream_normalizer.sv
`default_nettype none
// DNA stream normalizer: takes one file byte per cycle unless the result
// register is held by a stalled sink, and returns at most one result per byte,
// lower-case bases a/c/g/t/u or the separator byte, with saturating base, input
// and output counters; an end-of-file item returns a summary with status and
// clears all parse state and counters. In FASTA mode the file must open with
// '>', header lines are skipped and newlines dropped. Each byte passes an input
// register, then classification and counter update into the result register.
// Configure through the APB port only while the stream is idle.
module fasta_dna_stream_normalizer import fdsn_pkg::*; #(
    parameter int COUNT_BITS = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    fdsn_in_if.sink                       i_in_chan,
    fdsn_out_if.source                    o_out_chan
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  advance;

    fdsn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fdsn_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in_chan),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    fdsn_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (item_valid),
        .i_item    (item),
        .i_cfg     (cfg),
        .o_advance (advance),
        .o_out     (o_out_chan)
    );

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import fdsn_pkg::*;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  symbol;
        logic                  is_summary;
        logic                  status;
        logic [FIELD_BITS-1:0] count_a;
        logic [FIELD_BITS-1:0] count_c;
        logic [FIELD_BITS-1:0] count_g;
        logic [FIELD_BITS-1:0] count_t;
        logic [FIELD_BITS-1:0] input_count;
        logic [FIELD_BITS-1:0] output_count;
    } t_result;

    localparam int POST_DRAIN_CYCLES = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    logic                 src_valid = 1'b0;
    logic [BYTE_BITS-1:0] src_byte  = '0;
    logic                 src_eof   = 1'b0;
    logic                 sink_ready = 1'b0;
    int                   stall_left = 0;
    bit                   steady = 1'b0;

    int items_sent    = 0;
    int results_seen  = 0;
    int files_sent    = 0;
    int mismatches    = 0;

    // testbench copy of the block state and configuration
    t_cfg                  cfg_model;
    t_phase                parse_ph;
    logic                  run_open;
    logic                  rec_nonempty;
    logic [FIELD_BITS-1:0] base_cnt [NUM_BASES];
    logic [FIELD_BITS-1:0] consumed;
    logic [FIELD_BITS-1:0] emitted;

    t_result stream_results_q [$];

    fdsn_in_if  in_ch ();
    fdsn_out_if out_ch ();

    assign in_ch.valid       = src_valid;
    assign in_ch.data_byte   = src_byte;
    assign in_ch.end_of_file = src_eof;
    assign out_ch.ready      = sink_ready;

    fasta_dna_stream_normalizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_chan  (in_ch),
        .o_out_chan (out_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [FIELD_BITS-1:0] sat_inc(logic [FIELD_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void clear_parse();
        parse_ph     = PH_EXPECT;
        run_open     = 1'b0;
        rec_nonempty = 1'b0;
        for (int i = 0; i < NUM_BASES; i++) base_cnt[i] = '0;
        consumed = '0;
        emitted  = '0;
    endfunction

    function automatic t_result make_result(logic [BYTE_BITS-1:0] sym, logic summ, logic stat);
        t_result r;
        r.symbol       = sym;
        r.is_summary   = summ;
        r.status       = stat;
        r.count_a      = base_cnt[BASE_A];
        r.count_c      = base_cnt[BASE_C];
        r.count_g      = base_cnt[BASE_G];
        r.count_t      = base_cnt[BASE_T];
        r.input_count  = consumed;
        r.output_count = emitted;
        return r;
    endfunction

    // one sequence byte: fold case, count, emit base or open a separator run
    function automatic bit seq_symbol(logic [BYTE_BITS-1:0] raw, output t_result r);
        logic [BYTE_BITS-1:0] b;
        logic [1:0]           idx;
        bit                   is_base;
        b = raw;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) b = b | CH_CASE_BIT;
        consumed     = sat_inc(consumed);
        rec_nonempty = 1'b1;
        is_base      = 1'b1;
        idx          = BASE_A;
        case (b)
            CH_A: idx = BASE_A;
            CH_C: idx = BASE_C;
            CH_G: idx = BASE_G;
            CH_T, CH_U: idx = BASE_T;
            default: is_base = 1'b0;
        endcase
        if (!is_base) begin
            if (run_open) return 1'b0;
            run_open = 1'b1;
            emitted  = sat_inc(emitted);
            r = make_result(cfg_model.separator_code, 1'b0, 1'b0);
            return 1'b1;
        end
        run_open      = 1'b0;
        base_cnt[idx] = sat_inc(base_cnt[idx]);
        emitted       = sat_inc(emitted);
        r = make_result(b, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    function automatic bit normalize_byte(t_item it, output t_result r);
        logic stat;
        bit   emit;
        if (it.end_of_file) begin
            stat = (parse_ph == PH_ERROR) || (cfg_model.format_mode && parse_ph == PH_EXPECT);
            r = make_result(8'h00, 1'b1, stat);
            clear_parse();
            return 1'b1;
        end
        if (!cfg_model.format_mode) return seq_symbol(it.data_byte, r);
        case (parse_ph)
            PH_EXPECT: begin
                if (it.data_byte == CH_MARKER) parse_ph = PH_HEADER;
                else parse_ph = PH_ERROR;
                return 1'b0;
            end
            PH_HEADER: begin
                if (it.data_byte == CH_NEWLINE) begin
                    parse_ph     = PH_SEQ;
                    run_open     = 1'b0;
                    rec_nonempty = 1'b0;
                end
                return 1'b0;
            end
            PH_SEQ: begin
                if (it.data_byte == CH_NEWLINE) return 1'b0;
                if (it.data_byte == CH_MARKER) begin
                    emit         = rec_nonempty;
                    parse_ph     = PH_HEADER;
                    rec_nonempty = 1'b0;
                    if (!emit) return 1'b0;
                    emitted = sat_inc(emitted);
                    r = make_result(cfg_model.separator_code, 1'b0, 1'b0);
                    return 1'b1;
                end
                return seq_symbol(it.data_byte, r);
            end
            default: return 1'b0;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            sink_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want,
                               input logic [FIELD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_out
        t_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && sink_ready) begin
            if (stream_results_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual symbol %0h summary %0b",
                         $time, out_ch.symbol, out_ch.is_summary);
                mismatches++;
            end else begin
                want = stream_results_q.pop_front();
                check_field("symbol", want.symbol, out_ch.symbol);
                check_field("is_summary", want.is_summary, out_ch.is_summary);
                check_field("status", want.status, out_ch.status);
                check_field("count_a", want.count_a, out_ch.count_a);
                check_field("count_c", want.count_c, out_ch.count_c);
                check_field("count_g", want.count_g, out_ch.count_g);
                check_field("count_t", want.count_t, out_ch.count_t);
                check_field("input_count", want.input_count, out_ch.input_count);
                check_field("output_count", want.output_count, out_ch.output_count);
                results_seen++;
            end
        end
    end

    task automatic put_byte(input logic [BYTE_BITS-1:0] b, input logic eof);
        int      gap;
        t_item   it;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_valid <= 1'b1;
        src_byte  <= b;
        src_eof   <= eof;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        it.data_byte   = b;
        it.end_of_file = eof;
        if (normalize_byte(it, r)) stream_results_q.push_back(r);
        items_sent++;
        if (eof) files_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
    endtask

    task automatic end_file();
        put_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b1);
    endtask

    // wait until the block is idle, with margin for bytes that return nothing
    task automatic drain();
        src_valid <= 1'b0;
        @(posedge i_clk);
        while (stream_results_q.size() != 0) @(posedge i_clk);
        repeat (POST_DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DATA_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] rd;
        logic [APB_DATA_BITS-1:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_FORMAT_MODE) begin
            cfg_model.format_mode = value[0];
            mask = 32'h1;
        end else begin
            cfg_model.separator_code = value[BYTE_BITS-1:0];
            mask = 32'hFF;
        end
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((rd & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, idx, value & mask, rd & mask);
            mismatches++;
        end
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_seq_byte();
        string bases;
        int    r;
        bases = "acgtuACGTU";
        r = $urandom_range(0, 99);
        if (r < 55) return bases[$urandom_range(0, 9)];
        if (r < 65) return CH_NEWLINE;
        if (r < 68) return CH_MARKER;
        return BYTE_BITS'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_header_byte();
        logic [BYTE_BITS-1:0] b;
        b = BYTE_BITS'($urandom_range(0, 255));
        if (b == CH_NEWLINE) b = 8'h5F;
        return b;
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_separator();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return BYTE_BITS'($urandom_range(0, 255));
    endfunction

    // reset values of both registers, multi-record file with empty record
    task automatic test_reset_defaults();
        send_string(">r\nAcGtU\nNN-a\n>\n>q\nT");
        end_file();
        drain();
    endtask

    // empty input, missing marker with sticky error, end of file inside a header
    task automatic test_fasta_errors();
        end_file();
        send_string("x>A");
        end_file();
        send_string(">hd");
        end_file();
        drain();
    endtask

    // NUL, high bytes and folding edges in plain mode, separator extremes
    task automatic test_plain_bytes();
        write_reg(REG_FORMAT_MODE, 32'h0);
        write_reg(REG_SEPARATOR_CODE, 32'h0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h80, 1'b0);
        send_string("Z[@a>\n");
        drain();
        write_reg(REG_SEPARATOR_CODE, 32'hFF);
        put_byte(8'h7F, 1'b0);
        send_string("uG");
        end_file();
        drain();
    endtask

    // format mode flipped inside one file, parse phase carried across
    task automatic test_mode_switch();
        write_reg(REG_FORMAT_MODE, 32'h1);
        write_reg(REG_SEPARATOR_CODE, 32'h2E);
        send_string(">h\nAC");
        drain();
        write_reg(REG_FORMAT_MODE, 32'h0);
        send_string("\n>g");
        drain();
        write_reg(REG_FORMAT_MODE, 32'h1);
        send_string("T");
        end_file();
        send_string("x");
        drain();
        // error phase still reported in plain mode
        write_reg(REG_FORMAT_MODE, 32'h0);
        send_string("ac");
        end_file();
        drain();
    endtask

    task automatic test_random_fasta(input int target);
        int n_rec;
        int len;
        bit cut;
        while (items_sent < target) begin
            write_reg(REG_FORMAT_MODE, 32'h1);
            write_reg(REG_SEPARATOR_CODE, {24'h0, pick_separator()});
            steady = ($urandom_range(0, 4) == 0);
            cut = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                // broken start
                put_byte(pick_seq_byte(), 1'b0);
            end
            n_rec = $urandom_range(1, 4);
            for (int k = 0; k < n_rec && !cut; k++) begin
                put_byte(CH_MARKER, 1'b0);
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) put_byte(pick_header_byte(), 1'b0);
                if ($urandom_range(0, 14) == 0) begin
                    cut = 1'b1;
                end else begin
                    put_byte(CH_NEWLINE, 1'b0);
                    len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
                    for (int i = 0; i < len; i++) put_byte(pick_seq_byte(), 1'b0);
                end
            end
            end_file();
            drain();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_plain(input int target);
        int len;
        while (items_sent < target) begin
            write_reg(REG_FORMAT_MODE, 32'h0);
            write_reg(REG_SEPARATOR_CODE, {24'h0, pick_separator()});
            steady = ($urandom_range(0, 4) == 0);
            len = $urandom_range(10, 60);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 1) == 0) put_byte(pick_seq_byte(), 1'b0);
                else put_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
            end
            end_file();
            drain();
        end
        steady = 1'b0;
    endtask

    initial begin
        cfg_model.format_mode    = FORMAT_RESET;
        cfg_model.separator_code = SEPARATOR_RESET;
        clear_parse();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_fasta_errors();
        test_plain_bytes();
        test_mode_switch();
        test_random_fasta(1250);
        test_random_plain(1650);

        drain();
        $display("run covered %0d input items in %0d files, %0d results checked",
                 items_sent, files_sent, results_seen);
        $display("fasta and plain modes, error and empty-record cases, separator extremes");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d items still pending", $time, stream_results_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
